// ===== sv/ppu_pkg.sv =====
// Package for the particle pool update block: shared types and constants.
// Depends on nothing; used by the controller, datapath and top level.
package ppu_pkg;

  localparam int PosW   = 24;
  localparam int LifeW  = 17;
  localparam int ColW   = 9;
  localparam int DtW    = 16;
  localparam int RndW   = 7;
  localparam int CntW   = 7;
  localparam int SlotW  = 6;
  localparam logic [LifeW-1:0] LifeOne = 17'd65536;

  typedef struct packed {
    logic spawn_write;
    logic tick_write;
    logic load_item;
  } ppu_cmd_t;

  function automatic logic signed [PosW-1:0] sat24(input logic signed [PosW+1:0] v);
    logic signed [PosW+1:0] hi;
    logic signed [PosW+1:0] lo;
    begin
      hi = 26'sd8388607;
      lo = -26'sd8388608;
      if (v > hi) sat24 = 24'sh7FFFFF;
      else if (v < lo) sat24 = 24'sh800000;
      else sat24 = v[PosW-1:0];
    end
  endfunction

endpackage

// ===== sv/ppu_ram.sv =====
// Generic RAM with one write port and one registered read port.
// No dependencies.
module ppu_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/ppu_ctrl.sv =====
// Controller state machine for the particle pool update block.
// Depends on ppu_pkg.
module ppu_ctrl import ppu_pkg::*; #(
  parameter int PoolSlots = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_op,
  input  logic [CntW-1:0]  slots_cfg,
  input  logic             slot_dead,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_last,
  output logic [SlotW-1:0] addr,
  output ppu_cmd_t         cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SREAD = 6'b000010,
    S_SCHK  = 6'b000100,
    S_TREAD = 6'b001000,
    S_TCALC = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic op;
  logic [SlotW-1:0] idx, start, found;
  logic [CntW-1:0] n, cnt;
  logic [CntW-1:0] eff;

  always_comb begin
    eff = slots_cfg;
    if (eff == '0) eff = CntW'(1);
    if (eff > CntW'(PoolSlots)) eff = CntW'(PoolSlots);
  end

  // Next index in the search: wrap to slot 0 at the end of slots in use.
  logic [SlotW-1:0] idx_inc;
  assign idx_inc = ({1'b0, idx} + CntW'(1) >= n) ? '0 : idx + SlotW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = in_op ? S_TREAD : S_SREAD;
      S_SREAD: state_next = S_SCHK;
      S_SCHK:  if (slot_dead || cnt + CntW'(1) >= n) state_next = S_OUT;
               else state_next = S_SREAD;
      S_TREAD: state_next = S_TCALC;
      S_TCALC: state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = (!op || cnt + CntW'(1) >= n) ? S_IDLE : S_TREAD;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_last  = !op || (cnt + CntW'(1) >= n);
  assign cmd.load_item   = (state == S_IDLE) && in_valid;
  assign cmd.tick_write  = (state == S_TCALC);
  assign cmd.spawn_write = (state == S_SCHK) && (slot_dead || cnt + CntW'(1) >= n);
  assign found = slot_dead ? idx : '0;
  assign addr  = (state == S_SCHK && !slot_dead && cnt + CntW'(1) >= n) ? '0 : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= '0;
      idx   <= '0;
      cnt   <= '0;
      n     <= CntW'(PoolSlots);
      op    <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (in_valid) begin
          op  <= in_op;
          n   <= eff;
          cnt <= '0;
          idx <= in_op ? '0 : (({1'b0, start} >= eff) ? '0 : start);
        end
        S_SCHK: begin
          if (slot_dead || cnt + CntW'(1) >= n) begin
            start <= found;
            idx   <= found;
          end else begin
            idx <= idx_inc;
            cnt <= cnt + CntW'(1);
          end
        end
        S_OUT: if (!out_stall && op) begin
          idx <= idx + SlotW'(1);
          cnt <= cnt + CntW'(1);
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== sv/ppu_dp.sv =====
// Datapath for the particle pool update block: slot memories and arithmetic.
// Depends on ppu_pkg and ppu_ram.
module ppu_dp import ppu_pkg::*; #(
  parameter int PoolSlots = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ppu_cmd_t               cmd,
  input  logic [SlotW-1:0]       addr,
  input  logic [DtW-1:0]         time_step,
  input  logic signed [PosW-1:0] source_pos_x,
  input  logic signed [PosW-1:0] source_pos_y,
  input  logic signed [PosW-1:0] source_vel_x,
  input  logic signed [PosW-1:0] source_vel_y,
  input  logic signed [PosW-1:0] spawn_offset_x,
  input  logic signed [PosW-1:0] spawn_offset_y,
  input  logic [RndW-1:0]        jitter_random,
  input  logic [RndW-1:0]        shade_random,
  output logic                   slot_dead,
  output logic                   alive,
  output logic signed [PosW-1:0] particle_x,
  output logic signed [PosW-1:0] particle_y,
  output logic [ColW-1:0]        red_level,
  output logic [ColW-1:0]        shade_level
);
  localparam int AW = $clog2(PoolSlots) > 0 ? $clog2(PoolSlots) : 1;

  logic [DtW-1:0] dt;
  logic signed [PosW+1:0] sx, sy;
  logic signed [PosW-1:0] vx_new, vy_new;
  logic [ColW-1:0] shade_new;
  logic [ColW:0] fade;

  logic signed [PosW-1:0] px_q, py_q, vx_q, vy_q;
  logic [ColW-1:0] red_q, shd_q;
  logic signed [PosW-1:0] px_w, py_w, vx_w, vy_w;
  logic [ColW-1:0] red_w, shd_w;
  logic we;
  // Valid bits give the reset value of zero for entries never written.
  logic [PoolSlots-1:0] written;
  logic wr_rd;

  // Life sits in a slot memory like the other fields; a slot not written
  // since reset reads as dead through its valid bit.
  logic [LifeW-1:0] rl;
  logic [LifeW-1:0] life_rd;
  logic [LifeW-1:0] life_w;
  logic life_we;
  assign life_rd   = wr_rd ? rl : '0;
  assign slot_dead = (life_rd == '0);

  function automatic logic signed [PosW-1:0] div10(input logic signed [PosW-1:0] v);
    logic [PosW-1:0] m;
    logic [PosW+31:0] p;
    logic [PosW-1:0] q;
    begin
      m = v[PosW-1] ? PosW'(-v) : v;
      p = (PosW+32)'(m + PosW'(5)) * (PosW+32)'(32'hCCCCCCCD);
      q = PosW'(p >> 35);
      div10 = v[PosW-1] ? -$signed(q) : $signed(q);
    end
  endfunction

  logic [RndW+8:0] jr, sr, jn;
  logic [31:0] jp, sp;
  logic signed [PosW-1:0] jit;
  always_comb begin
    jr = {1'b0, jitter_random, 8'b0};
    sr = {1'b0, shade_random, 8'b0} + 16'd50;
    jn = (jr >= 16'd12800) ? jr - 16'd12800 + 16'd5 : 16'd12800 - jr + 16'd5;
    // Division by 10 and by 100 as reciprocal products, exact over these ranges.
    jp = 32'(jn) * 32'd52429;
    sp = 32'(sr) * 32'd5243;
    if (jr >= 16'd12800) jit = PosW'(jp >> 19);
    else jit = -PosW'(jp >> 19);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      dt <= time_step;
      sx <= (PosW+2)'(source_pos_x) + (PosW+2)'(jit) + (PosW+2)'(spawn_offset_x);
      sy <= (PosW+2)'(source_pos_y) + (PosW+2)'(jit) + (PosW+2)'(spawn_offset_y);
      vx_new <= div10(source_vel_x);
      vy_new <= div10(source_vel_y);
      shade_new <= ColW'(9'd128 + ColW'(sp >> 19));
      fade <= (ColW+1)'((20'(time_step) * 20'd5 + 20'd256) >> 9);
    end
  end

  logic [LifeW-1:0] life_dec;
  assign life_dec = (life_rd > LifeW'(dt)) ? life_rd - LifeW'(dt) : '0;

  // Life is written on every spawn and every tick visit, so a particle that dies is stored as dead.
  assign life_we = cmd.spawn_write || cmd.tick_write;
  assign life_w  = cmd.spawn_write ? LifeOne : life_dec;

  logic signed [PosW+DtW:0] mxp, myp;
  logic signed [PosW+1:0] mx, my;
  always_comb begin
    mxp = $signed(vx_q) * $signed({1'b0, dt});
    myp = $signed(vy_q) * $signed({1'b0, dt});
    mx = mxp[PosW+DtW] ? -(PosW+2)'((-mxp + 32768) >>> 16) : (PosW+2)'((mxp + 32768) >>> 16);
    my = myp[PosW+DtW] ? -(PosW+2)'((-myp + 32768) >>> 16) : (PosW+2)'((myp + 32768) >>> 16);
  end

  always_comb begin
    we = cmd.spawn_write || (cmd.tick_write && life_dec != '0);
    if (cmd.spawn_write) begin
      px_w = sat24(sx); py_w = sat24(sy);
      vx_w = vx_new; vy_w = vy_new;
      red_w = shade_new; shd_w = shade_new;
    end else begin
      px_w = sat24((PosW+2)'(px_q) - mx);
      py_w = sat24((PosW+2)'(py_q) - my);
      vx_w = vx_q; vy_w = vy_q;
      red_w = ({1'b0, red_q} > fade) ? ColW'({1'b0, red_q} - fade) : '0;
      shd_w = shd_q;
    end
  end

  logic [PosW-1:0] rx, ry, rvx, rvy;
  logic [ColW-1:0] rr, rs;
  ppu_ram #(.Width(LifeW), .Depth(PoolSlots)) u_life (.clk, .we(life_we),
    .waddr(addr[AW-1:0]), .wdata(life_w), .raddr(addr[AW-1:0]), .rdata(rl));
  ppu_ram #(.Width(PosW), .Depth(PoolSlots)) u_px (.clk, .we, .waddr(addr[AW-1:0]),
    .wdata(px_w), .raddr(addr[AW-1:0]), .rdata(rx));
  ppu_ram #(.Width(PosW), .Depth(PoolSlots)) u_py (.clk, .we, .waddr(addr[AW-1:0]),
    .wdata(py_w), .raddr(addr[AW-1:0]), .rdata(ry));
  ppu_ram #(.Width(PosW), .Depth(PoolSlots)) u_vx (.clk, .we, .waddr(addr[AW-1:0]),
    .wdata(vx_w), .raddr(addr[AW-1:0]), .rdata(rvx));
  ppu_ram #(.Width(PosW), .Depth(PoolSlots)) u_vy (.clk, .we, .waddr(addr[AW-1:0]),
    .wdata(vy_w), .raddr(addr[AW-1:0]), .rdata(rvy));
  ppu_ram #(.Width(ColW), .Depth(PoolSlots)) u_rd (.clk, .we, .waddr(addr[AW-1:0]),
    .wdata(red_w), .raddr(addr[AW-1:0]), .rdata(rr));
  ppu_ram #(.Width(ColW), .Depth(PoolSlots)) u_sh (.clk, .we, .waddr(addr[AW-1:0]),
    .wdata(shd_w), .raddr(addr[AW-1:0]), .rdata(rs));

  always_ff @(posedge clk) wr_rd <= written[addr[AW-1:0]];

  always_comb begin
    px_q  = wr_rd ? $signed(rx)  : '0;
    py_q  = wr_rd ? $signed(ry)  : '0;
    vx_q  = wr_rd ? $signed(rvx) : '0;
    vy_q  = wr_rd ? $signed(rvy) : '0;
    red_q = wr_rd ? rr : '0;
    shd_q = wr_rd ? rs : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else begin
      if (we) written[addr[AW-1:0]] <= 1'b1;
    end
  end

  // Output register, loaded with what was written to the slot, or with its old contents where nothing was written.
  always_ff @(posedge clk) begin
    if (cmd.spawn_write || cmd.tick_write) begin
      alive       <= cmd.spawn_write || (life_dec != '0);
      particle_x  <= we ? px_w : px_q;
      particle_y  <= we ? py_w : py_q;
      red_level   <= we ? red_w : red_q;
      shade_level <= we ? shd_w : shd_q;
    end
  end
endmodule

// ===== sv/particle_pool_update.sv =====
// Particle pool update: top level joining the controller and the datapath.
// Depends on ppu_pkg, ppu_ctrl, ppu_dp and ppu_ram.
//
// Usage. One input channel (in_valid / in_stall) takes a request: a spawn
// (operation 0) or a tick (operation 1). The output channel (out_valid /
// out_stall) returns one result per slot reported, with last set on the final
// result of the request. The user must write the register slots_in_use through
// cfg_we / cfg_data only while idle (not enforced); it is clamped to 1..POOL_SLOTS.
//
// Operation. A spawn scans slots in turn from the roving start slot, each
// through a memory read and a check, until it finds a dead slot or has checked
// the n slots in use; then its single result appears. A tick visits each slot
// in turn in three steps (memory read, update and write, output). The single
// read port of each slot memory is why the slots are visited one at a time.
// Only one request is in flight at a time.
//
// Reset. A synchronous reset kills every particle, zeroes the search start,
// and sets slots_in_use to 64. When the receiver stalls, the current result
// holds and the scan waits.
module particle_pool_update import ppu_pkg::*; #(
  parameter int POOL_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CntW-1:0]        cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [DtW-1:0]         time_step,
  input  logic signed [PosW-1:0] source_pos_x,
  input  logic signed [PosW-1:0] source_pos_y,
  input  logic signed [PosW-1:0] source_vel_x,
  input  logic signed [PosW-1:0] source_vel_y,
  input  logic signed [PosW-1:0] spawn_offset_x,
  input  logic signed [PosW-1:0] spawn_offset_y,
  input  logic [RndW-1:0]        jitter_random,
  input  logic [RndW-1:0]        shade_random,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SlotW-1:0]       slot_index,
  output logic                   alive,
  output logic signed [PosW-1:0] particle_x,
  output logic signed [PosW-1:0] particle_y,
  output logic [ColW-1:0]        red_level,
  output logic [ColW-1:0]        shade_level,
  output logic                   last
);
  logic [CntW-1:0] slots_in_use;
  ppu_cmd_t cmd;
  logic slot_dead;
  logic [SlotW-1:0] addr;

  // The configuration register.
  always_ff @(posedge clk) begin
    if (rst) slots_in_use <= CntW'(64);
    else if (cfg_we) slots_in_use <= cfg_data;
  end

  ppu_ctrl #(.PoolSlots(POOL_SLOTS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_op(operation), .slots_cfg(slots_in_use),
    .slot_dead, .out_stall, .out_valid, .out_last(last), .addr, .cmd
  );

  ppu_dp #(.PoolSlots(POOL_SLOTS)) u_dp (
    .clk, .rst, .cmd, .addr, .time_step, .source_pos_x, .source_pos_y,
    .source_vel_x, .source_vel_y, .spawn_offset_x, .spawn_offset_y,
    .jitter_random, .shade_random, .slot_dead, .alive, .particle_x,
    .particle_y, .red_level, .shade_level
  );

  // The slot being reported is the controller's current address.
  assign slot_index = addr;

  // A new request is never taken while a result is on offer.
  a_no_accept_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken during output");

  // A spawned particle always reports as alive.
  a_spawn_alive: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.spawn_write) |-> alive) else $error("spawned slot not alive");

  // Shade never falls below 128, a quarter of its 9-bit range.
  a_shade_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alive) |-> shade_level >= ColW'(128)) else $error("shade too low");
endmodule
